/* rtl/level_sensor_debounce_sequencer_assert.svh */
// assertion macros shared by the level sensor debounce sequencer rtl
// all macros sample on clk and are held off while rst_n is low
`ifndef LEVEL_SENSOR_DEBOUNCE_SEQUENCER_ASSERT_SVH
`define LEVEL_SENSOR_DEBOUNCE_SEQUENCER_ASSERT_SVH

// expression must hold at every clock edge out of reset
`define LSDS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("lsds invariant violated");

// consequent must hold in the same cycle as the antecedent
`define LSDS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsds implication violated");

// consequent must hold in the cycle after the antecedent
`define LSDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsds next-cycle check violated");

`endif

/* rtl/lsds_pkg.sv */
package lsds_pkg;

  // sensor and time geometry
  localparam int SENSOR_COUNT = 7;
  localparam int TIME_BITS    = 32;
  localparam int LEVEL_W      = $clog2(SENSOR_COUNT + 1);
  localparam int DEB_W        = 16;
  localparam int OP_W         = 2;
  localparam int DIR_W        = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_IDLE  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FILL  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_EMPTY = 2'd2;
  localparam logic [DIR_W-1:0] DIR_ERROR = 2'd3;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_BITS  = SENSOR_COUNT + TIME_BITS;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = SENSOR_COUNT + 2 * LEVEL_W + DIR_W + 4 + TIME_BITS;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [DEB_W-1:0] DEB_RESET = 16'd50;

  // command queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic sample;
    logic check;
    logic clear;
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [SENSOR_COUNT-1:0]   raw;
    logic [TIME_BITS-1:0]      now;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]    last_change_ms;
    logic                    tank_empty;
    logic                    tank_full;
    logic                    contiguous_ok;
    logic                    sequence_fault;
    logic [DIR_W-1:0]        direction_state;
    logic [LEVEL_W-1:0]      prior_level;
    logic [LEVEL_W-1:0]      level;
    logic [SENSOR_COUNT-1:0] level_bits;
  } result_t;

endpackage

/* rtl/lsds_front.sv */
module lsds_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lsds_pkg::OP_W-1:0]           in_tuser,
  input  logic [lsds_pkg::IN_DATA_W-1:0]      in_tdata,
  input  lsds_pkg::fifo_stat_t                fifo_stat,
  output logic                                push,
  output lsds_pkg::cmd_t                      cmd
);

  // accept whenever the queue has room
  assign in_tready = !fifo_stat.full;
  assign push      = in_tvalid && !fifo_stat.full;

  // classify the operation and unpack the payload; the spare code behaves as a plain sample
  always_comb begin
    cmd.kind = '0;
    unique case (in_tuser)
      lsds_pkg::OP_SAMPLE: cmd.kind.sample = 1'b1;
      lsds_pkg::OP_CHECK: begin
        cmd.kind.sample = 1'b1;
        cmd.kind.check  = 1'b1;
      end
      lsds_pkg::OP_CLEAR: cmd.kind.clear = 1'b1;
      lsds_pkg::OP_SPARE: cmd.kind.sample = 1'b1;
    endcase
    cmd.raw = in_tdata[lsds_pkg::SENSOR_COUNT-1:0];
    cmd.now = in_tdata[lsds_pkg::SENSOR_COUNT +: lsds_pkg::TIME_BITS];
  end

endmodule

/* rtl/lsds_fifo.sv */
module lsds_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lsds_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output lsds_pkg::cmd_t       head_cmd,
  output lsds_pkg::fifo_stat_t stat
);

  lsds_pkg::cmd_t                   mem_r [lsds_pkg::FIFO_DEPTH];
  logic [lsds_pkg::FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lsds_pkg::FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lsds_pkg::FIFO_CNT_W-1:0]  count_r, count_nxt;

  localparam logic [lsds_pkg::FIFO_PTR_W-1:0] PTR_LAST =
    lsds_pkg::FIFO_PTR_W'(lsds_pkg::FIFO_DEPTH - 1);
  localparam logic [lsds_pkg::FIFO_CNT_W-1:0] CNT_FULL =
    lsds_pkg::FIFO_CNT_W'(lsds_pkg::FIFO_DEPTH);

  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/lsds_back.sv */
module lsds_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsds_pkg::cmd_t                cmd,
  input  logic                          cmd_empty,
  output logic                          pop,
  input  logic [lsds_pkg::DEB_W-1:0]    debounce_ms,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output lsds_pkg::result_t             result
);

  localparam int NS = lsds_pkg::SENSOR_COUNT;
  localparam int TB = lsds_pkg::TIME_BITS;
  localparam int LW = lsds_pkg::LEVEL_W;
  localparam logic [LW-1:0] LEVEL_FULL = LW'(NS);

  // sensor state
  logic [NS-1:0]                  raw_prev_r, raw_prev_nxt;
  logic [TB-1:0]                  stable_r [NS];
  logic [TB-1:0]                  stable_nxt [NS];
  logic [NS-1:0]                  deb_r, deb_nxt;
  logic [LW-1:0]                  level_r, level_nxt;
  logic [lsds_pkg::DIR_W-1:0]     dir_r, dir_nxt;
  logic                           fault_r, fault_nxt;
  logic [TB-1:0]                  stamp_r, stamp_nxt;
  logic                           ok;

  // output register
  logic                           out_valid_r;
  lsds_pkg::result_t              result_r, result_nxt;

  logic [TB-1:0]                  threshold;
  logic [TB-1:0]                  elapsed [NS];
  logic [NS-1:0]                  passed;
  logic [NS-1:0]                  deb_sample;
  logic [LW-1:0]                  level_sample;
  logic [NS-1:0]                  expect_mask;

  assign pop        = !cmd_empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign result     = result_r;
  assign threshold  = {{(TB - lsds_pkg::DEB_W){1'b0}}, debounce_ms};

  // per sensor timer restart and debounce
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      stable_nxt[i] = (cmd.raw[i] ^ raw_prev_r[i]) ? cmd.now : stable_r[i];
      elapsed[i]    = cmd.now - stable_nxt[i];
      passed[i]     = elapsed[i] > threshold;
      deb_sample[i] = passed[i] ? cmd.raw[i] : deb_r[i];
    end
  end

  // highest active sensor
  always_comb begin
    level_sample = '0;
    for (int i = 0; i < NS; i++) begin
      if (deb_sample[i]) begin
        level_sample = LW'(i + 1);
      end
    end
  end

  // contiguous pattern for the new level
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      expect_mask[i] = (LW'(i) < level_sample);
    end
  end

  // state update for one item
  always_comb begin
    raw_prev_nxt = raw_prev_r;
    deb_nxt      = deb_r;
    level_nxt    = level_r;
    dir_nxt      = dir_r;
    fault_nxt    = fault_r;
    stamp_nxt    = stamp_r;
    ok           = 1'b1;
    if (cmd.kind.clear) begin
      fault_nxt = 1'b0;
      dir_nxt   = lsds_pkg::DIR_IDLE;
    end else begin
      raw_prev_nxt = cmd.raw;
      deb_nxt      = deb_sample;
      level_nxt    = level_sample;
      if (deb_sample != deb_r) begin
        stamp_nxt = cmd.now;
      end
      // direction tracking
      priority if (level_sample > level_r) begin
        if (dir_r != lsds_pkg::DIR_FILL && dir_r != lsds_pkg::DIR_IDLE) begin
          if (level_r != '0) begin
            dir_nxt   = lsds_pkg::DIR_ERROR;
            fault_nxt = 1'b1;
          end
        end else begin
          dir_nxt = lsds_pkg::DIR_FILL;
        end
      end else if (level_sample < level_r) begin
        if (dir_r != lsds_pkg::DIR_EMPTY && dir_r != lsds_pkg::DIR_IDLE) begin
          dir_nxt   = lsds_pkg::DIR_ERROR;
          fault_nxt = 1'b1;
        end else begin
          dir_nxt = lsds_pkg::DIR_EMPTY;
        end
      end
      if ((level_sample == '0 || level_sample == LEVEL_FULL) && !fault_nxt) begin
        dir_nxt = lsds_pkg::DIR_IDLE;
      end
      // optional contiguity check
      if (cmd.kind.check && (deb_sample != expect_mask)) begin
        ok        = 1'b0;
        fault_nxt = 1'b1;
        dir_nxt   = lsds_pkg::DIR_ERROR;
      end
    end
  end

  // result fields
  always_comb begin
    result_nxt.level_bits      = deb_nxt;
    result_nxt.level           = level_nxt;
    result_nxt.prior_level     = level_r;
    result_nxt.direction_state = dir_nxt;
    result_nxt.sequence_fault  = fault_nxt;
    result_nxt.contiguous_ok   = ok;
    result_nxt.tank_full       = (level_nxt == LEVEL_FULL);
    result_nxt.tank_empty      = (level_nxt == '0);
    result_nxt.last_change_ms  = stamp_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r <= '0;
      for (int i = 0; i < NS; i++) begin
        stable_r[i] <= '0;
      end
      deb_r   <= '0;
      level_r <= '0;
      dir_r   <= lsds_pkg::DIR_IDLE;
      fault_r <= 1'b0;
      stamp_r <= '0;
    end else if (pop) begin
      raw_prev_r <= raw_prev_nxt;
      if (cmd.kind.sample) begin
        for (int i = 0; i < NS; i++) begin
          stable_r[i] <= stable_nxt[i];
        end
      end
      deb_r   <= deb_nxt;
      level_r <= level_nxt;
      dir_r   <= dir_nxt;
      fault_r <= fault_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      result_r <= result_nxt;
    end
  end

  `include "level_sensor_debounce_sequencer_assert.svh"

  // fault flag and error state always move together
  `LSDS_ASSERT_ALWAYS(a_fault_is_error, fault_r == (dir_r == lsds_pkg::DIR_ERROR))
  // no debounced sensor above the level
  `LSDS_ASSERT_ALWAYS(a_nothing_above_level, (deb_r >> level_r) == '0)
  // level zero means every sensor dry
  `LSDS_ASSERT_IMPL(a_empty_is_dry, level_r == '0, deb_r == '0)
  // a clear item leaves the fault cleared
  `LSDS_ASSERT_NEXT(a_clear_drops_fault, pop && cmd.kind.clear, !fault_r)

endmodule

/* rtl/level_sensor_debounce_sequencer.sv */
// level sensor debounce sequencer
// in_*  : stream of items, in_tuser = operation (sample, sample with contiguity
//         check, clear fault), in_tdata = raw sensor bits and millisecond stamp
// out_* : one result item per input item, in input order
// cfg_* : apb-style register port, one register (debounce_ms at address 0)
// an item is decoded by the front end and queued in a two-entry command queue;
// the back end debounces all sensors in parallel, updates level, direction
// and fault, and loads the result register in the cycle it pops the queue
// an accepted item is written into the queue, popped from its head and registered
// into the result register; the back end takes one item per cycle unless out_tready
// stalls it; a stalled out_tready holds the result register; the queue then fills
// and in_tready drops after two more items
// reset (synchronous, rst_n low): queue empty, no result pending, all sensor
// timers, debounced bits, level, direction and fault cleared, debounce_ms 50
module level_sensor_debounce_sequencer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [lsds_pkg::OP_W-1:0]             in_tuser,  // operation[1:0]
  input  logic [lsds_pkg::IN_DATA_W-1:0]        in_tdata,  // sensor_bits[6:0],
                                                           // now_ms[38:7], zero pad
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [lsds_pkg::OUT_DATA_W-1:0]       out_tdata, // level_bits[6:0],
                                                           // level[9:7],
                                                           // prior_level[12:10],
                                                           // direction_state[14:13],
                                                           // sequence_fault[15],
                                                           // contiguous_ok[16],
                                                           // tank_full[17],
                                                           // tank_empty[18],
                                                           // last_change_ms[50:19],
                                                           // zero pad
  // configuration port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [lsds_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [lsds_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [lsds_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  logic [lsds_pkg::DEB_W-1:0]     debounce_r, debounce_nxt;
  logic [lsds_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                           cfg_wr;

  lsds_pkg::fifo_stat_t           fifo_stat;
  lsds_pkg::cmd_t                 push_cmd, head_cmd;
  logic                           push, pop;
  lsds_pkg::result_t              result;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[lsds_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    debounce_nxt = debounce_r;
    if (cfg_wr && cfg_idx == lsds_pkg::REG_DEBOUNCE) begin
      debounce_nxt = cfg_pwdata[lsds_pkg::DEB_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_idx == lsds_pkg::REG_DEBOUNCE) begin
      cfg_prdata = {{(lsds_pkg::CFG_DATA_W - lsds_pkg::DEB_W){1'b0}}, debounce_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= lsds_pkg::DEB_RESET;
    end else begin
      debounce_r <= debounce_nxt;
    end
  end

  // decode and accept
  lsds_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .fifo_stat (fifo_stat),
    .push      (push),
    .cmd       (push_cmd)
  );

  // command queue
  lsds_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (fifo_stat)
  );

  // debounce, level and direction
  lsds_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (head_cmd),
    .cmd_empty   (fifo_stat.empty),
    .pop         (pop),
    .debounce_ms (debounce_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .result      (result)
  );

  // pack result fields, lowest first
  assign out_tdata = {{(lsds_pkg::OUT_DATA_W - lsds_pkg::OUT_DATA_BITS){1'b0}}, result};

endmodule

/* tb/sv/level_sensor_debounce_sequencer_test.sv */
module level_sensor_debounce_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lsds_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 300;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OP_W-1:0]       in_tuser  = '0;  // operation[1:0]
  logic [IN_DATA_W-1:0]  in_tdata  = '0;  // sensor_bits[6:0], now_ms[38:7], zero pad
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // level_bits, level, prior_level, direction,
                                          // fault, contiguous_ok, full, empty, stamp
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  level_sensor_debounce_sequencer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always #5 clk = ~clk;

  // shadow of the block's state
  logic [SENSOR_COUNT-1:0] sh_raw_last;
  logic [TIME_BITS-1:0]    sh_settle_start [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] sh_clean;
  logic [LEVEL_W-1:0]      sh_level;
  logic [DIR_W-1:0]        sh_dir;
  logic                    sh_fault;
  logic [TIME_BITS-1:0]    sh_stamp;
  logic [DEB_W-1:0]        sh_hold_ms;

  result_t level_reports_due[$];
  int      mismatches  = 0;
  int      cycle_count = 0;
  int      burst_left  = 0;

  // receiver pattern state
  bit rx_hold_req  = 1'b0;
  int rx_hold_left = 0;
  int rx_mode      = 0;
  int rx_mode_left = 0;

  // work out the next report and advance the shadow state
  function automatic result_t predict_level_report(logic [OP_W-1:0] op,
                                                   logic [SENSOR_COUNT-1:0] bits,
                                                   logic [TIME_BITS-1:0] now);
    result_t                 rep;
    logic [LEVEL_W-1:0]      prior;
    logic [LEVEL_W-1:0]      lvl;
    logic [TIME_BITS-1:0]    elapsed;
    logic [SENSOR_COUNT-1:0] run_mask;
    logic                    ok;
    prior = sh_level;
    ok    = 1'b1;
    if (op == OP_CLEAR) begin
      sh_fault = 1'b0;
      sh_dir   = DIR_IDLE;
    end else begin
      // per-sensor debounce
      lvl = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (bits[i] != sh_raw_last[i]) sh_settle_start[i] = now;
        elapsed = now - sh_settle_start[i];
        if (elapsed > TIME_BITS'(sh_hold_ms) && bits[i] != sh_clean[i]) begin
          sh_clean[i] = bits[i];
          sh_stamp    = now;
        end
        if (sh_clean[i]) lvl = LEVEL_W'(i + 1);
      end
      sh_raw_last = bits;
      prior    = sh_level;
      sh_level = lvl;
      // direction tracking
      if (sh_level > prior) begin
        if (sh_dir != DIR_FILL && sh_dir != DIR_IDLE) begin
          if (prior != 0) begin
            sh_dir   = DIR_ERROR;
            sh_fault = 1'b1;
          end
        end else begin
          sh_dir = DIR_FILL;
        end
      end else if (sh_level < prior) begin
        if (sh_dir != DIR_EMPTY && sh_dir != DIR_IDLE) begin
          sh_dir   = DIR_ERROR;
          sh_fault = 1'b1;
        end else begin
          sh_dir = DIR_EMPTY;
        end
      end
      if ((sh_level == 0 || sh_level == SENSOR_COUNT) && !sh_fault) sh_dir = DIR_IDLE;
      // active sensors must form a run from the bottom
      if (op == OP_CHECK) begin
        run_mask = SENSOR_COUNT'((8'd1 << sh_level) - 8'd1);
        if (sh_clean != run_mask) begin
          sh_fault = 1'b1;
          sh_dir   = DIR_ERROR;
          ok       = 1'b0;
        end
      end
    end
    rep.level_bits      = sh_clean;
    rep.level           = sh_level;
    rep.prior_level     = prior;
    rep.direction_state = sh_dir;
    rep.sequence_fault  = sh_fault;
    rep.contiguous_ok   = ok;
    rep.tank_full       = (sh_level == SENSOR_COUNT);
    rep.tank_empty      = (sh_level == 0);
    rep.last_change_ms  = sh_stamp;
    return rep;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0h actual %0h", $realtime, what, want, got);
  endtask

  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) note_mismatch(what, want, got);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_DATA_BITS-1:0];
      if (level_reports_due.size() == 0) begin
        note_mismatch("result item with nothing due", 0, out_tdata[31:0]);
      end else begin
        want = level_reports_due.pop_front();
        compare_field("level_bits", want.level_bits, got.level_bits);
        compare_field("level", want.level, got.level);
        compare_field("prior_level", want.prior_level, got.prior_level);
        compare_field("direction_state", want.direction_state, got.direction_state);
        compare_field("sequence_fault", want.sequence_fault, got.sequence_fault);
        compare_field("contiguous_ok", want.contiguous_ok, got.contiguous_ok);
        compare_field("tank_full", want.tank_full, got.tank_full);
        compare_field("tank_empty", want.tank_empty, got.tank_empty);
        compare_field("last_change_ms", want.last_change_ms, got.last_change_ms);
      end
    end
  end

  // receiver stalls: changing duty patterns plus an occasional long hold-off
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready   <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left <= LONG_STALL;
      out_tready   <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(16, 128);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= $urandom_range(0, 1);
        2:       out_tready <= ($urandom_range(0, 7) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // offer one item and hold it until accepted; valid stays high afterwards
  task automatic send_item(logic [OP_W-1:0] op, logic [SENSOR_COUNT-1:0] bits,
                           logic [TIME_BITS-1:0] now);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({now, bits});
    do @(posedge clk); while (!in_tready);
    level_reports_due.push_back(predict_level_report(op, bits, now));
  endtask

  // raw change followed by a sample just past the debounce window
  task automatic send_settled(logic [OP_W-1:0] op, logic [SENSOR_COUNT-1:0] bits,
                              logic [TIME_BITS-1:0] t0);
    send_item(OP_SAMPLE, bits, t0);
    send_item(op, bits, t0 + TIME_BITS'(sh_hold_ms) + 1);
  endtask

  // sender bursts with random gaps, some stretches without gaps
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait for every due result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (level_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_DEBOUNCE, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sh_hold_ms = value[DEB_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_read_check();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {REG_DEBOUNCE, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    compare_field("debounce_ms readback", sh_hold_ms, cfg_prdata[DEB_W-1:0]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // change the debounce time while the block is idle
  task automatic set_debounce(logic [DEB_W-1:0] hold);
    drain_results();
    cfg_write({16'($urandom()), hold});
    cfg_read_check();
  endtask

  task automatic test_register_reset();
    cfg_read_check();
  endtask

  // hand-picked walk through fill, full, empty, reversal, clear and wrap
  task automatic test_directed();
    send_item(OP_SAMPLE, 7'h00, 32'h0000_0000);
    send_item(OP_SAMPLE, 7'h01, 32'd100);
    send_item(OP_SAMPLE, 7'h01, 32'd150);      // exactly the window: not yet taken
    send_item(OP_SAMPLE, 7'h01, 32'd151);
    send_settled(OP_SAMPLE, 7'h03, 32'd200);
    send_settled(OP_CHECK, 7'h7F, 32'd300);    // full, back to idle
    send_settled(OP_SAMPLE, 7'h3F, 32'd400);   // emptying
    send_settled(OP_SAMPLE, 7'h7F, 32'd500);   // reversal raises the fault
    send_settled(OP_SAMPLE, 7'h00, 32'd600);
    send_settled(OP_SAMPLE, 7'h01, 32'd700);   // rise from zero while in error
    send_item(OP_CLEAR, 7'h7F, 32'hFFFF_FFFF);
    send_settled(OP_CHECK, 7'h05, 32'd800);    // gap in the run of sensors
    send_item(OP_CLEAR, 7'h00, 32'h0000_0000);
    send_item(OP_SPARE, 7'h03, 32'hFFFF_FFF0);
    send_item(OP_SPARE, 7'h03, 32'h0000_0023); // window crosses the wrap
    send_item(OP_SAMPLE, 7'h03, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 7'h03, 32'h0000_0000);
  endtask

  // fill the block while the receiver holds off, then pause until empty
  task automatic test_backpressure();
    logic [TIME_BITS-1:0] t;
    t = $urandom();
    drain_results();
    rx_hold_req = 1'b1;
    for (int k = 0; k < 40; k++) begin
      t = t + $urandom_range(0, 2 * sh_hold_ms + 2);
      send_item(OP_SAMPLE, SENSOR_COUNT'((8'd1 << (k / 5 % 8)) - 8'd1), t);
    end
    drain_results();
  endtask

  // mostly thermometer fill and drain runs with bounce, jumps and reversals
  task automatic drive_traffic(int count);
    logic [TIME_BITS-1:0]    t;
    logic [SENSOR_COUNT-1:0] bits;
    logic [OP_W-1:0]         op;
    int                      lvl;
    bit                      rising;
    int                      pick;
    int unsigned             span;
    t      = $urandom();
    lvl    = $urandom_range(0, SENSOR_COUNT);
    rising = $urandom_range(0, 1);
    span   = 2 * int'(sh_hold_ms) + 2;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)       op = OP_CLEAR;
      else if (pick < 24) op = OP_CHECK;
      else if (pick < 30) op = OP_SPARE;
      else                op = OP_SAMPLE;
      pick = $urandom_range(0, 99);
      bits = SENSOR_COUNT'((8'd1 << lvl) - 8'd1);
      if (pick >= 88)      bits = $urandom();
      else if (pick >= 75) bits[$urandom_range(0, SENSOR_COUNT - 1)] ^= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 8)       t = t;
      else if (pick < 18) t = t + TIME_BITS'(sh_hold_ms);
      else if (pick < 28) t = t + TIME_BITS'(sh_hold_ms) + 1;
      else if (pick < 96) t = t + $urandom_range(0, span);
      else                t = $urandom();
      send_item(op, bits, t);
      pace_sender();
      // move the water level
      if ($urandom_range(0, 19) == 0) rising = !rising;
      if ($urandom_range(0, 2) == 0) begin
        if (rising && lvl == SENSOR_COUNT) rising = 1'b0;
        else if (!rising && lvl == 0)     rising = 1'b1;
        lvl = rising ? lvl + 1 : lvl - 1;
      end
    end
  endtask

  task automatic test_debounce_sweep();
    drive_traffic(280);
    set_debounce(16'd0);
    drive_traffic(280);
    set_debounce(16'hFFFF);
    drive_traffic(280);
    set_debounce(16'($urandom_range(1, 200)));
    drive_traffic(280);
    set_debounce(16'($urandom()));
    drive_traffic(280);
  endtask

  initial begin
    sh_raw_last = '0;
    foreach (sh_settle_start[i]) sh_settle_start[i] = '0;
    sh_clean   = '0;
    sh_level   = '0;
    sh_dir     = DIR_IDLE;
    sh_fault   = 1'b0;
    sh_stamp   = '0;
    sh_hold_ms = DEB_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_directed();
    test_backpressure();
    test_debounce_sweep();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
